/* hw/rtl/skyatl_pkg.sv */
// Shared types and default constants for the skyline atlas allocator.
// Depends on nothing; every other file of the block imports it.
package skyatl_pkg;

    localparam int NUM_ATLASES_DEF  = 2;
    localparam int ATLAS_WIDTH_DEF  = 256;
    localparam int ATLAS_HEIGHT_DEF = 256;

    localparam int SEL_W  = 1;
    localparam int SIZE_W = 9;
    localparam int POS_W  = 8;

    typedef struct packed {
        logic [SIZE_W-1:0] rect_height;
        logic [SIZE_W-1:0] rect_width;
        logic [SEL_W-1:0]  atlas_select;
    } req_t;

    typedef struct packed {
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_x;
        logic             placed;
    } res_t;

endpackage

/* hw/rtl/skyatl_heights.sv */
// Column height memory of all atlases, one synchronous read and one write port.
// Holds the clearing pass that zeroes every entry after reset; uses skyatl_pkg.
module skyatl_heights #(
    parameter int DEPTH = 512,
    parameter int HW    = 9
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [HW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [HW-1:0]            wr_data,
    output logic                     clr_busy
);
    import skyatl_pkg::*;

    localparam int AWD = $clog2(DEPTH);

    logic [HW-1:0]  heights_mem [DEPTH];
    logic [HW-1:0]  rd_data_reg;
    logic [AWD-1:0] clr_cnt_reg;
    logic [AWD-1:0] clr_cnt_next;
    logic           clr_busy_reg;
    logic           clr_busy_next;
    logic           mem_we;
    logic [AWD-1:0] mem_wa;
    logic [HW-1:0]  mem_wd;

    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            clr_cnt_next = clr_cnt_reg + AWD'(1);
            if (clr_cnt_reg == AWD'(DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    assign mem_we = clr_busy_reg | wr_en;
    assign mem_wa = clr_busy_reg ? clr_cnt_reg : wr_addr;
    assign mem_wd = clr_busy_reg ? '0 : wr_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heights_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= heights_mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

/* hw/rtl/skyatl_engine.sv */
// Request sequencer: block-wise prefix and suffix maxima over one atlas skyline,
// best position search, and write-back of the raised columns. Uses skyatl_pkg.
module skyatl_engine #(
    parameter int NUM_ATLASES  = skyatl_pkg::NUM_ATLASES_DEF,
    parameter int ATLAS_WIDTH  = skyatl_pkg::ATLAS_WIDTH_DEF,
    parameter int ATLAS_HEIGHT = skyatl_pkg::ATLAS_HEIGHT_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         req_valid,
    output logic                                         req_ready,
    input  skyatl_pkg::req_t                             req,
    input  logic                                         clr_busy,
    output logic                                         col_rd_en,
    output logic [$clog2(NUM_ATLASES*ATLAS_WIDTH)-1:0]   col_rd_addr,
    input  logic [$clog2(ATLAS_HEIGHT+1)-1:0]            col_rd_data,
    output logic                                         col_wr_en,
    output logic [$clog2(NUM_ATLASES*ATLAS_WIDTH)-1:0]   col_wr_addr,
    output logic [$clog2(ATLAS_HEIGHT+1)-1:0]            col_wr_data,
    output logic                                         res_valid,
    input  logic                                         res_ready,
    output skyatl_pkg::res_t                             res
);
    import skyatl_pkg::*;

    localparam int CW  = $clog2(ATLAS_WIDTH);
    localparam int AWD = $clog2(NUM_ATLASES * ATLAS_WIDTH);
    localparam int HW  = $clog2(ATLAS_HEIGHT + 1);
    localparam int SW  = ((HW > SIZE_W) ? HW : SIZE_W) + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREFIX = 3'd1;
    localparam logic [2:0] ST_TURN   = 3'd2;
    localparam logic [2:0] ST_SUFFIX = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_DECIDE = 3'd5;
    localparam logic [2:0] ST_WRITE  = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    logic [HW-1:0] scratch_mem [ATLAS_WIDTH];

    logic [2:0]        state_reg,  state_next;
    logic [SIZE_W-1:0] w_reg,      w_next;
    logic [SIZE_W-1:0] h_reg,      h_next;
    logic [AWD-1:0]    base_reg,   base_next;
    logic [CW-1:0]     idx_reg,    idx_next;
    logic [SIZE_W-1:0] cnt_reg,    cnt_next;
    logic              pre_vld_reg, pre_vld_next;
    logic              suf_vld_reg, suf_vld_next;
    logic [CW-1:0]     idx_q_reg,  idx_q_next;
    logic [SIZE_W-1:0] cnt_q_reg,  cnt_q_next;
    logic              fresh_q_reg, fresh_q_next;
    logic [HW-1:0]     run_reg,    run_next;
    logic [HW-1:0]     best_reg,   best_next;
    logic [CW-1:0]     bx_reg,     bx_next;
    logic              found_reg,  found_next;
    logic [AWD-1:0]    wb_addr_reg, wb_addr_next;
    logic [SIZE_W-1:0] wb_cnt_reg, wb_cnt_next;
    res_t              res_reg,    res_next;
    logic [HW-1:0]     sc_rd_reg;

    logic              sc_rd_en;
    logic [CW-1:0]     sc_rd_addr;
    logic              sc_wr_en;
    logic [HW-1:0]     pre_val;
    logic [HW-1:0]     suf_val;
    logic [HW-1:0]     win_max;
    logic              in_range;
    logic [SW-1:0]     new_top;
    logic              refuse;

    assign pre_val = (cnt_q_reg == '0 || col_rd_data > run_reg) ? col_rd_data : run_reg;
    assign suf_val = (fresh_q_reg || col_rd_data > run_reg) ? col_rd_data : run_reg;
    assign win_max = (sc_rd_reg > suf_val) ? sc_rd_reg : suf_val;
    assign in_range = (32'(idx_q_reg) + 32'(w_reg)) <= ATLAS_WIDTH;
    assign new_top  = SW'(best_reg) + SW'(h_reg);
    assign refuse   = (32'(req.atlas_select) >= NUM_ATLASES) || (req.rect_width == '0) ||
                      (req.rect_height == '0) || (32'(req.rect_width) > ATLAS_WIDTH);

    assign sc_rd_en   = (state_reg == ST_SUFFIX);
    assign sc_rd_addr = CW'(32'(idx_reg) + 32'(w_reg) - 32'd1);
    assign sc_wr_en   = pre_vld_reg;

    always_ff @(posedge aclk) begin
        if (sc_wr_en) begin
            scratch_mem[idx_q_reg] <= pre_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (sc_rd_en) begin
            sc_rd_reg <= scratch_mem[sc_rd_addr];
        end
    end

    always_comb begin
        state_next   = state_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        base_next    = base_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        pre_vld_next = 1'b0;
        suf_vld_next = 1'b0;
        idx_q_next   = idx_reg;
        cnt_q_next   = cnt_reg;
        fresh_q_next = (idx_reg == CW'(ATLAS_WIDTH - 1)) || (cnt_reg == w_reg - SIZE_W'(1));
        run_next     = run_reg;
        best_next    = best_reg;
        bx_next      = bx_reg;
        found_next   = found_reg;
        wb_addr_next = wb_addr_reg;
        wb_cnt_next  = wb_cnt_reg;
        res_next     = res_reg;
        req_ready    = (state_reg == ST_IDLE) && !clr_busy;
        res_valid    = (state_reg == ST_FINISH);
        col_rd_en    = 1'b0;
        col_rd_addr  = base_reg + AWD'(idx_reg);
        col_wr_en    = 1'b0;
        col_wr_addr  = wb_addr_reg;
        col_wr_data  = HW'(new_top);

        if (pre_vld_reg) begin
            run_next = pre_val;
        end
        if (suf_vld_reg) begin
            run_next = suf_val;
            if (in_range && win_max < HW'(ATLAS_HEIGHT) && win_max <= best_reg) begin
                best_next  = win_max;
                bx_next    = idx_q_reg;
                found_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (req_valid && req_ready) begin
                    w_next     = req.rect_width;
                    h_next     = req.rect_height;
                    base_next  = req.atlas_select[0] ? AWD'(ATLAS_WIDTH) : '0;
                    idx_next   = '0;
                    cnt_next   = '0;
                    best_next  = HW'(ATLAS_HEIGHT);
                    bx_next    = '0;
                    found_next = 1'b0;
                    res_next   = '0;
                    state_next = refuse ? ST_FINISH : ST_PREFIX;
                end
            end
            ST_PREFIX: begin
                col_rd_en    = 1'b1;
                pre_vld_next = 1'b1;
                idx_next     = idx_reg + CW'(1);
                cnt_next     = (cnt_reg == w_reg - SIZE_W'(1)) ? '0 : cnt_reg + SIZE_W'(1);
                if (idx_reg == CW'(ATLAS_WIDTH - 1)) begin
                    state_next = ST_TURN;
                end
            end
            ST_TURN: begin
                idx_next   = CW'(ATLAS_WIDTH - 1);
                cnt_next   = cnt_q_reg;
                state_next = ST_SUFFIX;
            end
            ST_SUFFIX: begin
                col_rd_en    = 1'b1;
                suf_vld_next = 1'b1;
                idx_next     = idx_reg - CW'(1);
                cnt_next     = (cnt_reg == '0) ? w_reg - SIZE_W'(1) : cnt_reg - SIZE_W'(1);
                if (idx_reg == '0) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (found_reg && new_top <= SW'(ATLAS_HEIGHT)) begin
                    res_next.placed = 1'b1;
                    res_next.pos_x  = POS_W'(bx_reg);
                    res_next.pos_y  = POS_W'(best_reg);
                    wb_addr_next    = base_reg + AWD'(bx_reg);
                    wb_cnt_next     = w_reg;
                    state_next      = ST_WRITE;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_WRITE: begin
                col_wr_en    = 1'b1;
                wb_addr_next = wb_addr_reg + AWD'(1);
                wb_cnt_next  = wb_cnt_reg - SIZE_W'(1);
                if (wb_cnt_reg == SIZE_W'(1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pre_vld_reg <= 1'b0;
            suf_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pre_vld_reg <= pre_vld_next;
            suf_vld_reg <= suf_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg       <= w_next;
        h_reg       <= h_next;
        base_reg    <= base_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        idx_q_reg   <= idx_q_next;
        cnt_q_reg   <= cnt_q_next;
        fresh_q_reg <= fresh_q_next;
        run_reg     <= run_next;
        best_reg    <= best_next;
        bx_reg      <= bx_next;
        found_reg   <= found_next;
        wb_addr_reg <= wb_addr_next;
        wb_cnt_reg  <= wb_cnt_next;
        res_reg     <= res_next;
    end

    assign res = res_reg;

endmodule

/* hw/rtl/skyline_atlas_allocator.sv */
// Skyline rectangle allocator over several texture atlases: top level with the
// stream ports and result register. Instantiates skyatl_heights and skyatl_engine.
//
// After reset the block zeroes the column memory, one entry per cycle, over all
// NUM_ATLASES * ATLAS_WIDTH entries, and s_tready stays low until that is done.
// Each request is then handled on its own: two passes over the atlas columns
// through the single read port of the column memory (block-wise prefix maxima
// left to right, then after a turnaround state suffix maxima and the window
// compare right to left), drain and decision states, a write-back of rect_width
// columns when the rectangle is placed, and the hand-over to the result register.
// A refused request skips the passes and the write-back. The next request may
// be accepted while the previous result still waits on the master side.
module skyline_atlas_allocator #(
    parameter int NUM_ATLASES  = skyatl_pkg::NUM_ATLASES_DEF,
    parameter int ATLAS_WIDTH  = skyatl_pkg::ATLAS_WIDTH_DEF,
    parameter int ATLAS_HEIGHT = skyatl_pkg::ATLAS_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rect_width [8:0], rect_height [17:9], zero fill
    input  logic [0:0]  s_tuser,   // atlas_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pos_x [7:0], pos_y [15:8]
    output logic [0:0]  m_tuser    // placed
);
    import skyatl_pkg::*;

    localparam int DEPTH = NUM_ATLASES * ATLAS_WIDTH;
    localparam int AWD   = $clog2(DEPTH);
    localparam int HW    = $clog2(ATLAS_HEIGHT + 1);

    req_t           req;
    res_t           res;
    logic           res_valid;
    logic           res_ready;
    logic           clr_busy;
    logic           col_rd_en;
    logic [AWD-1:0] col_rd_addr;
    logic [HW-1:0]  col_rd_data;
    logic           col_wr_en;
    logic [AWD-1:0] col_wr_addr;
    logic [HW-1:0]  col_wr_data;
    logic           m_tvalid_reg, m_tvalid_next;
    res_t           out_reg,      out_next;

    assign req.atlas_select = s_tuser;
    assign req.rect_width   = s_tdata[8:0];
    assign req.rect_height  = s_tdata[17:9];

    skyatl_heights #(
        .DEPTH (DEPTH),
        .HW    (HW)
    ) u_heights (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (col_rd_en),
        .rd_addr  (col_rd_addr),
        .rd_data  (col_rd_data),
        .wr_en    (col_wr_en),
        .wr_addr  (col_wr_addr),
        .wr_data  (col_wr_data),
        .clr_busy (clr_busy)
    );

    skyatl_engine #(
        .NUM_ATLASES  (NUM_ATLASES),
        .ATLAS_WIDTH  (ATLAS_WIDTH),
        .ATLAS_HEIGHT (ATLAS_HEIGHT)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req         (req),
        .clr_busy    (clr_busy),
        .col_rd_en   (col_rd_en),
        .col_rd_addr (col_rd_addr),
        .col_rd_data (col_rd_data),
        .col_wr_en   (col_wr_en),
        .col_wr_addr (col_wr_addr),
        .col_wr_data (col_wr_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.pos_y, out_reg.pos_x};
    assign m_tuser  = out_reg.placed;

    a_no_accept_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn) clr_busy |-> !s_tready
    ) else $error("request accepted during the clearing pass");

    a_no_write_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn) clr_busy |-> !col_wr_en
    ) else $error("column write issued during the clearing pass");

    a_result_loaded: assert property (
        @(posedge aclk) disable iff (!aresetn) (res_valid && res_ready) |=> m_tvalid
    ) else $error("finished result did not reach the output register");

    a_accept_leaves_idle: assert property (
        @(posedge aclk) disable iff (!aresetn) (s_tvalid && s_tready) |=> !s_tready
    ) else $error("second transaction accepted before the first was handled");

endmodule

/* sim/skyatl_placement_checker.sv */
`timescale 1ns / 1ps
// Placement checker for the skyline atlas allocator: keeps its own copy of every
// atlas skyline, predicts each placement from the accepted requests and compares
// it with the results on the master side. Depends on skyatl_pkg for the layouts.
module skyatl_placement_checker #(
    parameter int NUM_ATLASES  = skyatl_pkg::NUM_ATLASES_DEF,
    parameter int ATLAS_WIDTH  = skyatl_pkg::ATLAS_WIDTH_DEF,
    parameter int ATLAS_HEIGHT = skyatl_pkg::ATLAS_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // rect_width [8:0], rect_height [17:9], zero fill
    input  logic [0:0]  s_tuser,   // atlas_select
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // pos_x [7:0], pos_y [15:8]
    input  logic [0:0]  m_tuser,   // placed
    output int          mismatches,
    output int          outstanding,
    output int          placed_count,
    output int          refused_count
);

    int unsigned skyline [NUM_ATLASES][ATLAS_WIDTH];
    skyatl_pkg::res_t pending_placements [$];
    int n_mismatch = 0;
    int n_placed = 0;
    int n_refused = 0;
    int n_results = 0;

    function automatic skyatl_pkg::res_t place_rect(input skyatl_pkg::req_t req);
        skyatl_pkg::res_t res;
        int unsigned w;
        int unsigned h;
        int unsigned best;
        int unsigned best_x;
        int unsigned top;
        bit found;
        res = '0;
        w = 32'(req.rect_width);
        h = 32'(req.rect_height);
        best = ATLAS_HEIGHT;
        best_x = 0;
        found = 1'b0;
        if (req.atlas_select >= NUM_ATLASES || w == 0 || h == 0 || w > ATLAS_WIDTH) begin
            return res;
        end
        // Leftmost window whose tallest column is strictly the lowest, rightmost one included.
        for (int unsigned p = 0; p + w <= ATLAS_WIDTH; p++) begin
            top = 0;
            for (int unsigned k = 0; k < w; k++) begin
                if (skyline[req.atlas_select][p + k] > top) begin
                    top = skyline[req.atlas_select][p + k];
                end
            end
            if (top < best) begin
                best = top;
                best_x = p;
                found = 1'b1;
            end
        end
        if (!found || best + h > ATLAS_HEIGHT) begin
            return res;
        end
        for (int unsigned k = 0; k < w; k++) begin
            skyline[req.atlas_select][best_x + k] = best + h;
        end
        res.placed = 1'b1;
        res.pos_x = skyatl_pkg::POS_W'(best_x);
        res.pos_y = skyatl_pkg::POS_W'(best);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input skyatl_pkg::res_t got,
                                   input skyatl_pkg::res_t want);
        $display({"[%0t] result %0d, %s: got placed=%0d x=%0d y=%0d, ",
                  "expected placed=%0d x=%0d y=%0d"},
                 $realtime, n_results, what, got.placed, got.pos_x, got.pos_y,
                 want.placed, want.pos_x, want.pos_y);
        n_mismatch++;
    endtask

    always @(posedge aclk) begin
        skyatl_pkg::req_t req;
        skyatl_pkg::res_t want;
        skyatl_pkg::res_t got;
        if (!aresetn) begin
            foreach (skyline[a, c]) skyline[a][c] = 0;
            pending_placements.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                req.atlas_select = s_tuser[0];
                req.rect_width = s_tdata[8:0];
                req.rect_height = s_tdata[17:9];
                want = place_rect(req);
                if (want.placed) begin
                    n_placed++;
                end else begin
                    n_refused++;
                end
                pending_placements.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.placed = m_tuser[0];
                got.pos_x = m_tdata[7:0];
                got.pos_y = m_tdata[15:8];
                if (pending_placements.size() == 0) begin
                    report_mismatch("no request outstanding", got, '0);
                end else begin
                    want = pending_placements.pop_front();
                    if (got !== want) begin
                        report_mismatch("wrong placement", got, want);
                    end
                end
                n_results++;
            end
        end
        outstanding <= pending_placements.size();
        mismatches <= n_mismatch;
        placed_count <= n_placed;
        refused_count <= n_refused;
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Top of the skyline atlas allocator testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on skyatl_pkg, the block
// and skyatl_placement_checker, which does all the prediction and comparison.
module tb_top;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1000;
    localparam int RANDOM_PER_PHASE = 145;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    int mismatches;
    int outstanding;
    int placed_count;
    int refused_count;
    int src_idle = 31;
    int sink_idle = 59;
    int requests_sent = 0;
    int quiet_cycles = 0;

    skyline_atlas_allocator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    skyatl_placement_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .placed_count  (placed_count),
        .refused_count (refused_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= sink_idle);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("No transaction for %0d cycles.", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_request(input logic atlas, input logic [8:0] width,
                                input logic [8:0] height);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, height, width};
        s_tuser <= atlas;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Mostly small rectangles so the skylines fill slowly, with some wide, tall and
    // out-of-range requests mixed in.
    task automatic run_random_phase(input int src_pct, input int sink_pct);
        int unsigned pick;
        int unsigned w;
        int unsigned h;
        src_idle = src_pct;
        sink_idle = sink_pct;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                w = $urandom_range(48, 1);
                h = $urandom_range(6, 1);
            end else if (pick < 87) begin
                w = $urandom_range(256, 1);
                h = $urandom_range(24, 1);
            end else if (pick < 89) begin
                w = $urandom_range(256, 96);
                h = $urandom_range(256, 64);
            end else begin
                w = $urandom_range(511);
                h = $urandom_range(511);
            end
            push_request(1'($urandom_range(1)), 9'(w), 9'(h));
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        push_request(1'b0, 256, 1);
        push_request(1'b0, 1, 256);
        push_request(1'b0, 0, 5);
        push_request(1'b0, 5, 0);
        push_request(1'b0, 257, 1);
        push_request(1'b1, 511, 511);
        push_request(1'b1, 1, 511);
        push_request(1'b1, 1, 256);
        push_request(1'b1, 256, 1);
        push_request(1'b1, 255, 1);
        push_request(1'b0, 255, 10);
        push_request(1'b0, 1, 3);
        push_request(1'b1, 16, 255);
        push_request(1'b1, 16, 256);
        push_request(1'b0, 128, 128);
        push_request(1'b1, 100, 64);
        push_request(1'b0, 1, 1);
        push_request(1'b1, 1, 1);

        run_random_phase(31, 59);
        run_random_phase(59, 31);
        run_random_phase(0, 0);
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests to both atlases under three pacing mixes.", requests_sent);
        $display("Of these %0d were placed and %0d refused or did not fit.",
                 placed_count, refused_count);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
